FILE: hdl/segment_allocator_table_unit_assert.svh
// Assertion macros shared by the segment allocator table RTL.
`ifndef SEGMENT_ALLOCATOR_TABLE_UNIT_ASSERT_SVH
`define SEGMENT_ALLOCATOR_TABLE_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SAT_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SAT_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

FILE: hdl/sat_pkg.sv
// Package with codes and constants of the segment allocator table.
package sat_pkg;
  localparam int unsigned MAX_SEGMENTS = 16;
  localparam int unsigned ADDR_BITS = 16;
  localparam int unsigned SIZE_W = ADDR_BITS + 1;
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS) + 1;
  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;
  localparam logic [1:0] KIND_TEST = 2'd3;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOFIT = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_ZERO = 3'd4;
  localparam logic CFG_POOL = 1'b0;
  localparam logic CFG_SMALL = 1'b1;
endpackage

FILE: hdl/segment_allocator_table_unit.sv
// Top level of the segment allocator table.
//
// Channel | Direction | Handshake
// in_*    | in        | start && !busy
// out_*   | out       | out_valid, one cycle, no back-pressure
// cfg_*   | in        | cfg_we
//
// Tests and out-of-range requests go straight to the statistics scan; a read or a refused
// allocate first reads its entry. A split allocate shifts the entries above index i up and
// a free that merges a neighbor shifts the entries above it down: shifts move one entry per
// read and write pair, and the statistics scan reads one entry per cycle. Busy holds until
// the result shows in the first idle cycle.
// Reset and a pool size write restore one free segment without a clear pass.
// Results cannot be stalled.
module segment_allocator_table_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_kind,
  input  logic [3:0]                 in_segment_index,
  input  logic [16:0]                in_alloc_size,
  input  logic [15:0]                in_byte_address,
  output logic                       out_valid,
  output logic [2:0]                 out_status,
  output logic                       out_hit,
  output logic [15:0]                out_start,
  output logic [16:0]                out_size,
  output logic                       out_allocated,
  output logic [4:0]                 out_segment_total,
  output logic [4:0]                 out_free_segments,
  output logic [4:0]                 out_used_segments,
  output logic [16:0]                out_free_bytes,
  output logic [16:0]                out_largest_free,
  output logic [4:0]                 out_small_free_segments,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [16:0]                cfg_data
);
  import sat_pkg::*;
  `include "segment_allocator_table_unit_assert.svh"

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned LW = ADDR_BITS + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
  localparam logic [LW-1:0] POOLMAX = LW'(1) << ADDR_BITS;

  typedef struct packed {
    logic [AW-1:0] base;
    logic [LW-1:0] len;
    logic          used;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_EVAL, S_SHR_RD, S_SHR_WR, S_SPLIT, S_NXT_RD, S_NXT_EV,
    S_SHL_RD, S_SHL_WR, S_PRV_RD, S_PRV_EV, S_REP_RD, S_SCAN, S_DONE
  } state_t;

  ent_t mem [MAX_SEGMENTS];
  ent_t rd_r;
  logic [IW-1:0] raddr;
  logic          mre;
  logic          mwe;
  logic [IW-1:0] waddr;
  ent_t          wdata;

  state_t state_r;
  logic [CW-1:0] cnt_r;
  logic [LW-1:0] pool_r, small_r;
  logic [1:0] kind_r;
  logic [IW-1:0] idx_r, ri_r, ptr_r;
  logic [LW-1:0] size_r;
  logic [AW-1:0] addr_r;
  ent_t cur_r, rep_r;
  logic [2:0] status_r;
  logic hit_r, report_r, shl_merge_prev_r, scan_v_r, seed_r;
  logic [CW-1:0] scan_r;
  logic out_valid_r;

  logic st_clr, st_en;
  logic [CNT_W-1:0] s_nfree, s_nused, s_nsmall;
  logic [SIZE_W-1:0] s_fbytes, s_largest;

  // Entry zero is seeded at reset or pool write and read through a bypass.
  ent_t mrd;
  logic seedhit_r;
  always_comb begin
    mrd = rd_r;
    if (seedhit_r) mrd = '{base: '0, len: pool_r, used: 1'b0};
  end

  // The free remainder of a split lands right above the allocated part.
  ent_t split_rem;
  assign split_rem = '{base: mrd.base + size_r[AW-1:0], len: mrd.len - size_r, used: 1'b0};

  always_ff @(posedge clk) begin
    if (mwe) mem[waddr] <= wdata;
    if (mre) rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) seedhit_r <= 1'b0;
    else if (mre) seedhit_r <= seed_r && (raddr == '0);
  end

  logic [LW-1:0] cfg_pool;
  always_comb begin
    cfg_pool = cfg_data[LW-1:0];
    if (cfg_data == '0) cfg_pool = LW'(1);
    else if ({1'b0, cfg_data} > 18'(POOLMAX)) cfg_pool = POOLMAX;
  end

  logic [IW-1:0] idx_in;
  assign idx_in = IW'(in_segment_index);
  logic range_bad;
  assign range_bad = {1'b0, in_segment_index} >= 5'(cnt_r) ||
                     32'(in_segment_index) >= MAX_SEGMENTS;

  always_comb begin
    mre = 1'b0; raddr = ptr_r; mwe = 1'b0; waddr = ptr_r; wdata = cur_r;
    st_clr = 1'b0; st_en = 1'b0;
    unique case (state_r)
      S_IDLE: st_clr = 1'b1;
      S_RD, S_NXT_RD, S_PRV_RD, S_REP_RD, S_SHR_RD, S_SHL_RD: mre = 1'b1;
      S_SHR_WR: begin
        mwe = 1'b1; waddr = ptr_r + 1'b1;
        wdata = (ptr_r == idx_r) ? split_rem : mrd;
      end
      S_SHL_WR: begin mwe = 1'b1; waddr = ptr_r - 1'b1; wdata = mrd; end
      S_SPLIT: begin mwe = 1'b1; waddr = idx_r; wdata = cur_r; end
      S_SCAN: begin
        mre = {1'b0, scan_r} < {1'b0, cnt_r};
        raddr = scan_r[IW-1:0];
        st_en = scan_v_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= CW'(1); pool_r <= POOLMAX;
      small_r <= LW'(64); seed_r <= 1'b1; out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= state_r == S_DONE;
      if (cfg_we && cfg_index == CFG_POOL) begin
        pool_r <= cfg_pool; cnt_r <= CW'(1); seed_r <= 1'b1;
      end
      if (cfg_we && cfg_index == CFG_SMALL) small_r <= cfg_data;
      unique case (state_r)
        S_IDLE: if (start) begin
          kind_r <= in_kind; size_r <= in_alloc_size; addr_r <= in_byte_address;
          idx_r <= idx_in; ri_r <= idx_in; ptr_r <= idx_in; hit_r <= 1'b0;
          scan_r <= '0; scan_v_r <= 1'b0;
          if (in_kind == KIND_TEST) begin
            status_r <= ST_OK; report_r <= 1'b0; state_r <= S_SCAN;
          end else if (range_bad) begin
            status_r <= ST_RANGE; report_r <= 1'b0; state_r <= S_SCAN;
          end else begin
            status_r <= ST_OK; report_r <= 1'b1; state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_EVAL;
        S_EVAL: begin
          if (kind_r == KIND_ALLOC) begin
            if (size_r == '0) begin
              status_r <= ST_ZERO; state_r <= S_REP_RD;
            end else if (mrd.used || mrd.len < size_r) begin
              status_r <= ST_NOFIT; state_r <= S_REP_RD;
            end else if (mrd.len == size_r) begin
              cur_r <= '{base: mrd.base, len: mrd.len, used: 1'b1};
              state_r <= S_SPLIT;
            end else if (cnt_r >= MAXC) begin
              status_r <= ST_FULL; state_r <= S_REP_RD;
            end else begin
              ptr_r <= IW'(cnt_r - 1'b1); state_r <= S_SHR_RD;
            end
          end else if (kind_r == KIND_FREE && mrd.used) begin
            cur_r <= '{base: mrd.base, len: mrd.len, used: 1'b0};
            shl_merge_prev_r <= 1'b0;
            if ({1'b0, idx_r} + 1'b1 < cnt_r) begin
              ptr_r <= idx_r + 1'b1; state_r <= S_NXT_RD;
            end else if (idx_r != '0) begin
              ptr_r <= idx_r - 1'b1; state_r <= S_PRV_RD;
            end else state_r <= S_SPLIT;
          end else state_r <= S_REP_RD;
        end
        // Move entries from ptr up by one, from the top down to idx+1.
        S_SHR_RD: state_r <= S_SHR_WR;
        S_SHR_WR: begin
          if (ptr_r == idx_r) begin
            state_r <= S_SPLIT;
            cnt_r <= cnt_r + 1'b1;
            cur_r <= '{base: mrd.base, len: size_r, used: 1'b1};
          end else begin ptr_r <= ptr_r - 1'b1; state_r <= S_SHR_RD; end
        end
        S_SPLIT: begin
          seed_r <= seed_r && idx_r != '0;
          state_r <= S_REP_RD;
        end
        S_NXT_RD: state_r <= S_NXT_EV;
        S_NXT_EV: begin
          if (!mrd.used) begin
            cur_r <= '{base: cur_r.base, len: cur_r.len + mrd.len, used: 1'b0};
            shl_merge_prev_r <= 1'b1;
            if ({1'b0, idx_r} + 2'd2 < cnt_r) begin
              ptr_r <= idx_r + 2'd2; state_r <= S_SHL_RD;
            end else begin
              cnt_r <= cnt_r - 1'b1;
              if (idx_r != '0) begin
                ptr_r <= idx_r - 1'b1; state_r <= S_PRV_RD;
              end else state_r <= S_SPLIT;
            end
          end else if (idx_r != '0) begin
            ptr_r <= idx_r - 1'b1; state_r <= S_PRV_RD;
          end else state_r <= S_SPLIT;
        end
        S_SHL_RD: state_r <= S_SHL_WR;
        S_SHL_WR: begin
          if ({1'b0, ptr_r} + 1'b1 >= cnt_r) begin
            cnt_r <= cnt_r - 1'b1;
            if (shl_merge_prev_r && idx_r != '0) begin
              ptr_r <= idx_r - 1'b1; state_r <= S_PRV_RD;
            end else state_r <= S_SPLIT;
          end else begin ptr_r <= ptr_r + 1'b1; state_r <= S_SHL_RD; end
        end
        S_PRV_RD: state_r <= S_PRV_EV;
        S_PRV_EV: begin
          if (!mrd.used) begin
            // Grow the previous entry and close the gap at idx.
            cur_r <= '{base: mrd.base, len: mrd.len + cur_r.len, used: 1'b0};
            ri_r <= idx_r - 1'b1; idx_r <= idx_r - 1'b1;
            shl_merge_prev_r <= 1'b0;
            if ({1'b0, idx_r} + 1'b1 < cnt_r) begin
              ptr_r <= idx_r + 1'b1; state_r <= S_SHL_RD;
            end else begin cnt_r <= cnt_r - 1'b1; state_r <= S_SPLIT; end
          end else state_r <= S_SPLIT;
        end
        S_REP_RD: begin ptr_r <= ri_r; state_r <= S_SCAN; scan_r <= '0; end
        S_SCAN: begin
          if (kind_r != KIND_TEST && scan_r == '0 && report_r && !scan_v_r)
            rep_r <= '0;
          if (scan_v_r) begin
            if (kind_r == KIND_TEST && mrd.used && addr_r >= mrd.base &&
                {1'b0, addr_r} < {1'b0, mrd.base} + mrd.len) hit_r <= 1'b1;
            if (report_r && scan_r - 1'b1 == {1'b0, ri_r}) rep_r <= mrd;
          end
          scan_v_r <= {1'b0, scan_r} < {1'b0, cnt_r};
          scan_r <= scan_r + 1'b1;
          if (!({1'b0, scan_r} < {1'b0, cnt_r}) && !scan_v_r) state_r <= S_DONE;
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  sat_stats u_stats (
    .clk(clk), .rst_n(rst_n), .clr(st_clr), .en(st_en), .used(mrd.used),
    .len(mrd.len), .small_limit(small_r), .nfree(s_nfree), .nused(s_nused),
    .nsmall(s_nsmall), .fbytes(s_fbytes), .largest(s_largest)
  );

  assign busy = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_hit = hit_r;
  assign out_start = report_r && status_r != ST_RANGE ? 16'(rep_r.base) : '0;
  assign out_size = report_r && status_r != ST_RANGE ? 17'(rep_r.len) : '0;
  assign out_allocated = report_r && status_r != ST_RANGE ? rep_r.used : 1'b0;
  assign out_segment_total = 5'(cnt_r);
  assign out_free_segments = s_nfree;
  assign out_used_segments = s_nused;
  assign out_free_bytes = s_fbytes;
  assign out_largest_free = s_largest;
  assign out_small_free_segments = s_nsmall;

  `SAT_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r != '0 && cnt_r <= MAXC, "bad count")
  `SAT_ASSERT_NXT(a_done_valid, clk, rst_n, state_r == S_DONE, out_valid, "result missing")
  `SAT_ASSERT_IMP(a_stat_sum, clk, rst_n, out_valid, s_nfree + s_nused == cnt_r, "stat sum")
endmodule

FILE: hdl/sat_stats.sv
// Statistics accumulator fed with one table entry per cycle while en is high.
module sat_stats (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clr,
  input  logic                      en,
  input  logic                      used,
  input  logic [sat_pkg::SIZE_W-1:0] len,
  input  logic [sat_pkg::SIZE_W-1:0] small_limit,
  output logic [sat_pkg::CNT_W-1:0]  nfree,
  output logic [sat_pkg::CNT_W-1:0]  nused,
  output logic [sat_pkg::CNT_W-1:0]  nsmall,
  output logic [sat_pkg::SIZE_W-1:0] fbytes,
  output logic [sat_pkg::SIZE_W-1:0] largest
);
  import sat_pkg::*;
  logic [CNT_W-1:0] nfree_r, nused_r, nsmall_r;
  logic [SIZE_W-1:0] fbytes_r, largest_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      nfree_r <= '0;
      nused_r <= '0;
      nsmall_r <= '0;
      fbytes_r <= '0;
      largest_r <= '0;
    end else if (en) begin
      if (used) begin
        nused_r <= nused_r + 1'b1;
      end else begin
        nfree_r <= nfree_r + 1'b1;
        fbytes_r <= fbytes_r + len;
        if (len > largest_r) largest_r <= len;
        if (len < small_limit) nsmall_r <= nsmall_r + 1'b1;
      end
    end
  end

  assign nfree = nfree_r;
  assign nused = nused_r;
  assign nsmall = nsmall_r;
  assign fbytes = fbytes_r;
  assign largest = largest_r;
endmodule

FILE: tb/tb.sv
// Self-checking testbench for the segment allocator table: predicts and compares every result.
`timescale 1ns / 100ps

module tb;
  import sat_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic        hit;
    logic [15:0] seg_start;
    logic [16:0] seg_size;
    logic        allocated;
    logic [4:0]  segment_total;
    logic [4:0]  free_segments;
    logic [4:0]  used_segments;
    logic [16:0] free_bytes;
    logic [16:0] largest_free;
    logic [4:0]  small_free_segments;
  } seg_report_t;

  class segment_scoreboard;
    logic [15:0] base[16];
    logic [16:0] len[16];
    logic        used[16];
    int          count;
    logic [16:0] pool;
    logic [16:0] small_lim;
    seg_report_t pending_reports[$];
    int          errors;

    function new();
      pool = 17'd65536;
      small_lim = 17'd64;
      errors = 0;
      clear_table();
    endfunction

    function void clear_table();
      for (int i = 0; i < 16; i++) begin
        base[i] = '0;
        len[i] = '0;
        used[i] = 1'b0;
      end
      len[0] = pool;
      count = 1;
    endfunction

    function void write_reg(logic idx, logic [16:0] value);
      if (idx == CFG_POOL) begin
        if (value == 0) value = 17'd1;
        if (value > 17'd65536) value = 17'd65536;
        pool = value;
        clear_table();
      end else begin
        small_lim = value;
      end
    endfunction

    function void drop_entry(int k);
      for (int i = k; i + 1 < count; i++) begin
        base[i] = base[i + 1];
        len[i] = len[i + 1];
        used[i] = used[i + 1];
      end
      count--;
    endfunction

    function void note_request(logic [1:0] kind, logic [3:0] idx, logic [16:0] size,
                               logic [15:0] addr);
      seg_report_t r;
      bit report;
      int ri;
      int unsigned fbytes, largest;
      int nfree, nused, nsmall;
      r = '{default: '0};
      report = 0;
      ri = idx;
      fbytes = 0;
      largest = 0;
      nfree = 0;
      nused = 0;
      nsmall = 0;
      if (kind == KIND_TEST) begin
        for (int i = 0; i < count; i++)
          if (used[i] && int'(addr) >= int'(base[i]) && int'(addr) < int'(base[i]) + int'(len[i]))
            r.hit = 1'b1;
      end else if (idx >= count) begin
        r.status = ST_RANGE;
      end else if (kind == KIND_ALLOC) begin
        report = 1;
        if (size == 0) begin
          r.status = ST_ZERO;
        end else if (used[idx] || len[idx] < size) begin
          r.status = ST_NOFIT;
        end else if (len[idx] == size) begin
          used[idx] = 1'b1;
        end else if (count >= 16) begin
          r.status = ST_FULL;
        end else begin
          for (int i = count; i > idx + 1; i--) begin
            base[i] = base[i - 1];
            len[i] = len[i - 1];
            used[i] = used[i - 1];
          end
          base[idx + 1] = base[idx] + size[15:0];
          len[idx + 1] = len[idx] - size;
          used[idx + 1] = 1'b0;
          len[idx] = size;
          used[idx] = 1'b1;
          count++;
        end
      end else if (kind == KIND_FREE) begin
        report = 1;
        if (used[idx]) begin
          used[idx] = 1'b0;
          if (idx + 1 < count && !used[idx + 1]) begin
            len[idx] = len[idx] + len[idx + 1];
            drop_entry(idx + 1);
          end
          if (idx > 0 && !used[idx - 1]) begin
            len[idx - 1] = len[idx - 1] + len[idx];
            drop_entry(idx);
            ri = idx - 1;
          end
        end
      end else begin
        report = 1;
      end
      for (int i = 0; i < count; i++) begin
        if (used[i]) begin
          nused++;
        end else begin
          nfree++;
          fbytes += len[i];
          if (len[i] > largest) largest = len[i];
          if (len[i] < small_lim) nsmall++;
        end
      end
      if (report) begin
        r.seg_start = base[ri];
        r.seg_size = len[ri];
        r.allocated = used[ri];
      end
      r.segment_total = count[4:0];
      r.free_segments = nfree[4:0];
      r.used_segments = nused[4:0];
      r.free_bytes = fbytes[16:0];
      r.largest_free = largest[16:0];
      r.small_free_segments = nsmall[4:0];
      pending_reports.push_back(r);
    endfunction

    function void compare(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(seg_report_t a);
      seg_report_t e;
      if (pending_reports.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = pending_reports.pop_front();
      compare("status", e.status, a.status);
      compare("hit", e.hit, a.hit);
      compare("out_start", e.seg_start, a.seg_start);
      compare("out_size", e.seg_size, a.seg_size);
      compare("out_allocated", e.allocated, a.allocated);
      compare("segment_total", e.segment_total, a.segment_total);
      compare("free_segments", e.free_segments, a.free_segments);
      compare("used_segments", e.used_segments, a.used_segments);
      compare("free_bytes", e.free_bytes, a.free_bytes);
      compare("largest_free", e.largest_free, a.largest_free);
      compare("small_free_segments", e.small_free_segments, a.small_free_segments);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = '0;
  logic [3:0]  in_segment_index = '0;
  logic [16:0] in_alloc_size = '0;
  logic [15:0] in_byte_address = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic        out_hit;
  logic [15:0] out_start;
  logic [16:0] out_size;
  logic        out_allocated;
  logic [4:0]  out_segment_total;
  logic [4:0]  out_free_segments;
  logic [4:0]  out_used_segments;
  logic [16:0] out_free_bytes;
  logic [16:0] out_largest_free;
  logic [4:0]  out_small_free_segments;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [16:0] cfg_data = '0;

  segment_scoreboard sb = new();
  int cycles = 0;
  bit quiet = 0;

  segment_allocator_table_unit dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result('{out_status, out_hit, out_start, out_size, out_allocated,
                          out_segment_total, out_free_segments, out_used_segments,
                          out_free_bytes, out_largest_free, out_small_free_segments});
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_request(in_kind, in_segment_index, in_alloc_size,
                                          in_byte_address);
    end
  end

  task automatic send_request(logic [1:0] kind, logic [3:0] idx, logic [16:0] size,
                              logic [15:0] addr);
    @(negedge clk);
    start = 1'b1;
    in_kind = kind;
    in_segment_index = idx;
    in_alloc_size = size;
    in_byte_address = addr;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    if (!quiet && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 15)) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] value);
    while (sb.pending_reports.size() != 0 || busy) @(negedge clk);
    repeat (80) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_request();
    logic [1:0] kind;
    logic [3:0] idx;
    logic [16:0] size;
    logic [15:0] addr;
    int pick;
    kind = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 40) kind = KIND_ALLOC;
    else if (pick < 70) kind = KIND_FREE;
    idx = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, sb.count - 1));
    pick = $urandom_range(0, 19);
    if (pick == 0) size = 17'd0;
    else if (pick == 1) size = 17'($urandom);
    else if (pick < 5) size = sb.len[idx];
    else size = 17'($urandom_range(1, (sb.len[idx] > 2) ? sb.len[idx] / 3 : 1));
    addr = ($urandom_range(0, 3) == 0) ? 16'($urandom)
         : 16'($urandom_range(0, sb.pool - 1));
    send_request(kind, idx, size, addr);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    send_request(KIND_READ, 0, 0, 0);
    send_request(KIND_TEST, 0, 0, 0);
    send_request(KIND_ALLOC, 0, 17'd0, 0);
    send_request(KIND_ALLOC, 5, 17'd10, 0);
    send_request(KIND_FREE, 3, 0, 0);
    send_request(KIND_READ, 15, 0, 0);
    send_request(KIND_ALLOC, 0, 17'd100, 0);
    send_request(KIND_ALLOC, 1, 17'd65536, 0);
    send_request(KIND_ALLOC, 0, 17'd5, 0);
    send_request(KIND_TEST, 0, 0, 16'd50);
    send_request(KIND_TEST, 0, 0, 16'd100);
    send_request(KIND_ALLOC, 1, 17'd200, 0);
    send_request(KIND_ALLOC, 2, 17'd300, 0);
    send_request(KIND_FREE, 1, 0, 0);
    send_request(KIND_FREE, 1, 0, 0);
    send_request(KIND_FREE, 2, 0, 0);
    send_request(KIND_FREE, 0, 0, 0);
    send_request(KIND_ALLOC, 0, 17'd65536, 0);
    send_request(KIND_TEST, 0, 0, 16'hFFFF);
    send_request(KIND_FREE, 0, 0, 0);
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_POOL, 17'd0);
          write_reg(CFG_SMALL, 17'd0);
        end
        1: begin
          write_reg(CFG_POOL, 17'h1FFFF);
          write_reg(CFG_SMALL, 17'd65536);
        end
        2: begin
          write_reg(CFG_POOL, 17'd1000);
          write_reg(CFG_SMALL, 17'd40);
        end
        3: begin
          write_reg(CFG_POOL, 17'($urandom_range(16, 65536)));
          write_reg(CFG_SMALL, 17'h1FFFF);
        end
        4: begin
          write_reg(CFG_POOL, 17'd200);
          write_reg(CFG_SMALL, 17'($urandom_range(0, 200)));
        end
        default: begin
          write_reg(CFG_POOL, 17'd65536);
          write_reg(CFG_SMALL, 17'd64);
        end
      endcase
      for (int n = 0; n < 80; n++) begin
        quiet = (phase == 5 && n >= 40);
        random_request();
      end
    end
    while (sb.pending_reports.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
